// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the slot table checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/nfit_pkg.sv =====
// ----------------------------------------------------------------------------
// nfit_pkg
// Types, sizes, codes and helper functions of the next-fit slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfit_pkg;

  // Table geometry. The used flags are packed into words of FLAG_W bits.
  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int FLAG_W     = 32;
  localparam int BIT_W      = $clog2(FLAG_W);
  localparam int WORD_COUNT = SLOT_COUNT / FLAG_W;
  localparam int FLAG_AW    = $clog2(WORD_COUNT);
  localparam int PASS_W     = $clog2(WORD_COUNT + 1);

  // Field widths fixed by the interface.
  localparam int MODE_W  = 2;
  localparam int ID_W    = 16;
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = ID_W + IP_W + PORT_W;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   query_id;
    logic [IP_W-1:0]   client_ip;
    logic [PORT_W-1:0] client_port;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    logic [ID_W-1:0]   orig_id;
    logic [IP_W-1:0]   orig_ip;
    logic [PORT_W-1:0] orig_port;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } entry_t;

  // Index of the lowest set bit of a flag word; zero when no bit is set.
  function automatic logic [BIT_W-1:0] first_set(input logic [FLAG_W-1:0] vec);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = FLAG_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nfit_ram.sv =====
// ----------------------------------------------------------------------------
// nfit_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfit_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/next_fit_id_slot_table.sv =====
// ----------------------------------------------------------------------------
// next_fit_id_slot_table
// Query-ID translation table with next-fit slot allocation for a DNS relay.
// ----------------------------------------------------------------------------
// A command is transferred at a rising clock edge where start is high and busy
// is low. Every command gives exactly one result, shown on out_data for one
// cycle with out_valid high; the receiver cannot stall, so it must take the
// result in that cycle. Lookup, release and the unused mode pass from idle
// through the execute state back to idle, which registers their result. An
// allocate reads one word of 32 used flags per cycle from the flag memory,
// starting at the word that holds the scan cursor, and stops at the first
// free slot; it reads from 1 up to 33 flag words, 33 when the table is full
// (the cursor's own word is read again at the end for the slots below the
// cursor). After reset the block runs a clearing pass over all 32 words of
// the flag memory, during which busy stays high. A lookup of a free slot
// returns zero data with the slot-free status, and an allocate on a full
// table returns the table-full status and stores nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module next_fit_id_slot_table
  import nfit_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  localparam logic [FLAG_AW-1:0] WORD_LAST = FLAG_AW'(WORD_COUNT - 1);
  localparam logic [PASS_W-1:0]  PASS_LAST = PASS_W'(WORD_COUNT);

  logic [1:0]         state_r,     state_nxt;
  logic [FLAG_AW-1:0] clr_cnt_r,   clr_cnt_nxt;
  logic [SLOT_AW-1:0] cursor_r,    cursor_nxt;
  logic [FLAG_AW-1:0] word_r,      word_nxt;
  logic [PASS_W-1:0]  pass_r,      pass_nxt;
  in_item_t           item_r,      item_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  // Flag memory port signals.
  logic               flag_wr_en;
  logic [FLAG_AW-1:0] flag_wr_addr;
  logic [FLAG_W-1:0]  flag_wr_data;
  logic               flag_rd_en;
  logic [FLAG_AW-1:0] flag_rd_addr;
  logic [FLAG_W-1:0]  flag_rd;

  // Entry memory port signals.
  logic               ent_wr_en;
  logic [SLOT_AW-1:0] ent_wr_addr;
  entry_t             ent_wr_data;
  logic               ent_rd_en;
  logic [SLOT_AW-1:0] ent_rd_addr;
  logic [ENTRY_W-1:0] ent_rd_raw;
  entry_t             ent_rd;

  // Scan and command decode.
  logic               accept;
  logic [FLAG_AW-1:0] cur_word;
  logic [BIT_W-1:0]   cur_bit;
  logic [FLAG_W-1:0]  lo_mask;
  logic [FLAG_W-1:0]  scan_mask;
  logic [FLAG_W-1:0]  free_vec;
  logic               found;
  logic [BIT_W-1:0]   hit_bit;
  logic [SLOT_AW-1:0] hit_slot;
  logic [FLAG_AW-1:0] next_word;
  logic               idx_ok;
  logic [FLAG_AW-1:0] idx_word;
  logic [BIT_W-1:0]   idx_bit;
  logic [FLAG_AW-1:0] in_idx_word;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign cur_word = cursor_r[SLOT_AW-1:BIT_W];
  assign cur_bit  = cursor_r[BIT_W-1:0];

  // The first word read covers the cursor and the slots above it, the last
  // pass revisits the same word for the slots below the cursor.
  assign lo_mask   = (FLAG_W'(1) << cur_bit) - FLAG_W'(1);
  assign scan_mask = (pass_r == '0)        ? ~lo_mask :
                     (pass_r == PASS_LAST) ? lo_mask  : '1;
  assign free_vec  = ~flag_rd & scan_mask;
  assign found     = |free_vec;
  assign hit_bit   = first_set(free_vec);
  assign hit_slot  = {word_r, hit_bit};
  assign next_word = (word_r == WORD_LAST) ? '0 : word_r + FLAG_AW'(1);

  assign idx_ok      = (int'(item_r.slot_index) < SLOT_COUNT);
  assign idx_word    = item_r.slot_index[SLOT_AW-1:BIT_W];
  assign idx_bit     = item_r.slot_index[BIT_W-1:0];
  assign in_idx_word = in_data.slot_index[SLOT_AW-1:BIT_W];

  assign ent_rd = entry_t'(ent_rd_raw);

  // Memory access control. Only one command is in flight, and each one reads
  // a flag word before it writes the same word back, so no two accesses to
  // one entry can overlap and no forwarding path is needed.
  always_comb begin
    flag_wr_en   = 1'b0;
    flag_wr_addr = word_r;
    flag_wr_data = flag_rd;
    flag_rd_en   = 1'b0;
    flag_rd_addr = cur_word;
    ent_wr_en    = 1'b0;
    ent_wr_addr  = hit_slot;
    ent_wr_data  = '{id: item_r.query_id, ip: item_r.client_ip, port: item_r.client_port};
    ent_rd_en    = accept;
    ent_rd_addr  = in_data.slot_index[SLOT_AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        flag_wr_en   = 1'b1;
        flag_wr_addr = clr_cnt_r;
        flag_wr_data = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          flag_rd_en   = 1'b1;
          flag_rd_addr = (in_data.mode == MODE_ALLOC) ? cur_word : in_idx_word;
        end
      end
      ST_SCAN: begin
        if (found) begin
          flag_wr_en   = 1'b1;
          flag_wr_addr = word_r;
          flag_wr_data = flag_rd | (FLAG_W'(1) << hit_bit);
          ent_wr_en    = 1'b1;
        end else if (pass_r != PASS_LAST) begin
          flag_rd_en   = 1'b1;
          flag_rd_addr = next_word;
        end
      end
      ST_EXEC: begin
        if ((item_r.mode == MODE_RELEASE) && idx_ok) begin
          flag_wr_en   = 1'b1;
          flag_wr_addr = idx_word;
          flag_wr_data = flag_rd & ~(FLAG_W'(1) << idx_bit);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clearing pass, idle, allocate scan and execute.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    word_nxt      = word_r;
    pass_nxt      = pass_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + FLAG_AW'(1);
        if (clr_cnt_r == WORD_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_data;
          word_nxt  = cur_word;
          pass_nxt  = '0;
          state_nxt = (in_data.mode == MODE_ALLOC) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (found) begin
          cursor_nxt    = hit_slot;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.assigned_slot = SLOT_W'(hit_slot);
          out_data_nxt.status        = STAT_OK;
          state_nxt     = ST_IDLE;
        end else if (pass_r == PASS_LAST) begin
          // Every slot is in use: report it and leave the cursor alone.
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = STAT_FULL;
          state_nxt     = ST_IDLE;
        end else begin
          pass_nxt = pass_r + PASS_W'(1);
          word_nxt = next_word;
        end
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.status = STAT_OK;
        if (item_r.mode == MODE_LOOKUP) begin
          if (idx_ok && flag_rd[idx_bit]) begin
            out_data_nxt.orig_id   = ent_rd.id;
            out_data_nxt.orig_ip   = ent_rd.ip;
            out_data_nxt.orig_port = ent_rd.port;
          end else begin
            out_data_nxt.status = STAT_FREE;
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    pass_r     <= pass_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Used flags, one word of FLAG_W slots per entry.
  nfit_ram #(
    .DATA_W (FLAG_W),
    .ADDR_W (FLAG_AW)
  ) u_flag_ram (
    .clk     (clk),
    .wr_en   (flag_wr_en),
    .wr_addr (flag_wr_addr),
    .wr_data (flag_wr_data),
    .rd_en   (flag_rd_en),
    .rd_addr (flag_rd_addr),
    .rd_data (flag_rd)
  );

  // Stored query ID, client address and client port of every slot.
  nfit_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (SLOT_AW)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ENTRY_W'(ent_wr_data)),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_raw)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/nfit_checker.sv =====
// ----------------------------------------------------------------------------
// nfit_checker
// Port-level checks of the next-fit slot table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nfit_checker
  import nfit_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  logic xfer;

  assign xfer = start && !busy;

  // A transferred command keeps the block busy in the following cycle.
  `ASSERT_CLK_RST(a_busy_after_xfer, clk, rst_n, xfer |=> busy, "not busy after transfer")

  // A result comes only on the return to idle from a scan or execute state, so results never come back to back.
  `ASSERT_CLK_RST(a_no_twin_result, clk, rst_n, out_valid |=> !out_valid, "results back to back")

  // A result is always the answer to a command transferred earlier.
  `ASSERT_CLK_RST(a_result_has_cmd, clk, rst_n,
    out_valid |-> ($past(xfer) || $past(busy)), "result without a command")

  // A full table and a free slot both come with all-zero data fields.
  `ASSERT_CLK_RST(a_reject_zero, clk, rst_n,
    (out_valid && ((out_data.status == STAT_FULL) || (out_data.status == STAT_FREE))) |->
    ((out_data.assigned_slot == '0) && (out_data.orig_id == '0) &&
     (out_data.orig_ip == '0) && (out_data.orig_port == '0)), "reject carries data")

  // Only the three defined status codes are reported.
  `ASSERT_CLK_RST(a_status_code, clk, rst_n,
    out_valid |-> ((out_data.status == STAT_OK) || (out_data.status == STAT_FULL) ||
                   (out_data.status == STAT_FREE)), "bad status code")

endmodule

bind next_fit_id_slot_table nfit_checker u_nfit_checker (.*);

`default_nettype wire
